FILE: src/nrmc_pkg.sv
// shared types, constants and helpers for the rmc sentence decoder
package nrmc_pkg;

  localparam int unsigned MaxFracDigits = 5;
  localparam int unsigned QueueDepth    = 4;
  localparam int unsigned QueuePtrW     = $clog2(QueueDepth);

  localparam logic [3:0] FieldTime = 4'd1;
  localparam logic [3:0] FieldLat  = 4'd3;
  localparam logic [3:0] FieldNs   = 4'd4;
  localparam logic [3:0] FieldLon  = 4'd5;
  localparam logic [3:0] FieldEw   = 4'd6;
  localparam logic [3:0] FieldDate = 4'd9;
  localparam logic [3:0] FieldLast = 4'd15;

  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChStar   = 8'h2a;
  localparam logic [7:0] ChComma  = 8'h2c;
  localparam logic [7:0] ChMinus  = 8'h2d;
  localparam logic [7:0] ChPoint  = 8'h2e;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;
  localparam logic [7:0] ChR      = 8'h52;
  localparam logic [7:0] ChM      = 8'h4d;
  localparam logic [7:0] ChC      = 8'h43;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChLowZ   = 8'h7a;

  localparam logic [15:0] TalkerReset = 16'd18254;
  localparam logic [11:0] YearBase    = 12'd2000;

  // divisor select: a power of ten by its exponent, or sixty
  typedef enum logic [3:0] {
    DivP0   = 4'd0,
    DivP1   = 4'd1,
    DivP2   = 4'd2,
    DivP3   = 4'd3,
    DivP4   = 4'd4,
    DivP5   = 4'd5,
    DivP6   = 4'd6,
    DivP7   = 4'd7,
    DivBy60 = 4'd8
  } div_sel_e;

  // one field-closing transaction from the front to the back
  typedef struct packed {
    logic [3:0]  idx;
    logic [31:0] value;
    logic [2:0]  dx;
    logic [7:0]  first_byte;
    logic        term;
  } job_t;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    div_sel_e    sel;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quo;
    logic [31:0] rem;
  } div_rsp_t;

  function automatic logic [31:0] pow10(input logic [2:0] n);
    logic [31:0] r;
    case (n)
      3'd0: r = 32'd1;
      3'd1: r = 32'd10;
      3'd2: r = 32'd100;
      3'd3: r = 32'd1000;
      3'd4: r = 32'd10000;
      3'd5: r = 32'd100000;
      3'd6: r = 32'd1000000;
      default: r = 32'd10000000;
    endcase
    return r;
  endfunction

endpackage

FILE: src/nrmc_queue.sv
// small job queue between the byte front and the conversion back
module nrmc_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  nrmc_pkg::job_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output nrmc_pkg::job_t pop_data_o,
  output logic           empty_o
);

  nrmc_pkg::job_t mem_q [nrmc_pkg::QueueDepth];
  logic [nrmc_pkg::QueuePtrW-1:0] wr_q, rd_q;
  logic [nrmc_pkg::QueuePtrW:0]   cnt_q;

  assign full_o     = (cnt_q == (nrmc_pkg::QueuePtrW+1)'(nrmc_pkg::QueueDepth));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i && !full_o) wr_q <= wr_q + 1'b1;
      if (pop_i && !empty_o) rd_q <= rd_q + 1'b1;
      case ({push_i && !full_o, pop_i && !empty_o})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

FILE: src/nrmc_front.sv
// byte front: header hunt, comma counting and numeric field accumulation
module nrmc_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [15:0]    talker_id_i,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic [7:0]     rx_byte_i,
  input  logic           q_full_i,
  output logic           push_o,
  output nrmc_pkg::job_t job_o
);

  logic [15:0] talker_q;
  logic [2:0]  hp_q, hp_d;
  logic        ins_q, ins_d;
  logic [3:0]  fi_q, fi_d;
  logic [31:0] acc_q, acc_d;
  logic [2:0]  fd_q, fd_d;
  logic        sp_q, sp_d, neg_q, neg_d, bad_q, bad_d;
  logic [7:0]  fb_q, fb_d;

  logic        accept;
  logic [7:0]  exp_byte;
  logic [7:0]  b;
  logic [7:0]  fb_now;
  logic        term, bad;
  logic [35:0] nxt;
  logic [31:0] nxt_sat;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = q_full_i;
  assign accept      = in_valid_i && !q_full_i;
  assign b           = rx_byte_i;

  always_comb begin
    case (hp_q)
      3'd0:    exp_byte = nrmc_pkg::ChDollar;
      3'd1:    exp_byte = talker_q[15:8];
      3'd2:    exp_byte = talker_q[7:0];
      3'd3:    exp_byte = nrmc_pkg::ChR;
      3'd4:    exp_byte = nrmc_pkg::ChM;
      default: exp_byte = nrmc_pkg::ChC;
    endcase
  end

  assign nxt = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {32'd0, b[3:0] - 4'd0};
  assign nxt_sat = (nxt[35:32] != 4'd0) ? 32'hffff_ffff : nxt[31:0];
  assign fb_now  = (fi_q != 4'd0 && fb_q == 8'd0) ? b : fb_q;
  assign term    = (b == nrmc_pkg::ChStar) || (b < nrmc_pkg::ChSpace) || (b > nrmc_pkg::ChLowZ);
  assign bad     = (term && b != nrmc_pkg::ChStar) || bad_q || neg_q;

  always_comb begin
    hp_d   = hp_q;
    ins_d  = ins_q;
    fi_d   = fi_q;
    acc_d  = acc_q;
    fd_d   = fd_q;
    sp_d   = sp_q;
    neg_d  = neg_q;
    bad_d  = bad_q;
    fb_d   = fb_q;
    push_o = 1'b0;
    job_o.idx        = fi_q;
    job_o.value      = bad ? 32'd0 : acc_q;
    job_o.dx         = bad ? 3'd0 : fd_q;
    job_o.first_byte = fb_now;
    job_o.term       = term;
    if (accept) begin
      if (!ins_q) begin
        if (b == exp_byte) begin
          if (hp_q == 3'd5) begin
            hp_d  = 3'd0;
            ins_d = 1'b1;
            fi_d  = 4'd0;
            acc_d = '0;
            fd_d  = '0;
            sp_d  = 1'b0;
            neg_d = 1'b0;
            bad_d = 1'b0;
            fb_d  = '0;
          end else begin
            hp_d = hp_q + 3'd1;
          end
        end else begin
          hp_d = (b == nrmc_pkg::ChDollar) ? 3'd1 : 3'd0;
        end
      end else begin
        fb_d = fb_now;
        if (b == nrmc_pkg::ChComma || term) begin
          // only fields the back decodes, and the terminator, go in the queue
          push_o = term || fi_q == nrmc_pkg::FieldTime || fi_q == nrmc_pkg::FieldLat ||
                   fi_q == nrmc_pkg::FieldNs || fi_q == nrmc_pkg::FieldLon ||
                   fi_q == nrmc_pkg::FieldEw || fi_q == nrmc_pkg::FieldDate;
          if (term) begin
            ins_d = 1'b0;
            hp_d  = 3'd0;
          end else begin
            if (fi_q != nrmc_pkg::FieldLast) fi_d = fi_q + 4'd1;
            acc_d = '0;
            fd_d  = '0;
            sp_d  = 1'b0;
            neg_d = 1'b0;
            bad_d = 1'b0;
            fb_d  = '0;
          end
        end else if (b == nrmc_pkg::ChMinus) begin
          neg_d = 1'b1;
        end else if (b == nrmc_pkg::ChPoint) begin
          if (sp_q) bad_d = 1'b1;
          sp_d = 1'b1;
        end else if (b >= nrmc_pkg::ChZero && b <= nrmc_pkg::ChNine) begin
          if (!sp_q) begin
            acc_d = nxt_sat;
          end else if (fd_q < 3'(nrmc_pkg::MaxFracDigits)) begin
            acc_d = nxt_sat;
            fd_d  = fd_q + 3'd1;
          end
        end else begin
          bad_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      talker_q <= nrmc_pkg::TalkerReset;
      hp_q     <= '0;
      ins_q    <= 1'b0;
      fi_q     <= '0;
      acc_q    <= '0;
      fd_q     <= '0;
      sp_q     <= 1'b0;
      neg_q    <= 1'b0;
      bad_q    <= 1'b0;
      fb_q     <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) talker_q <= talker_id_i;
      hp_q  <= hp_d;
      ins_q <= ins_d;
      fi_q  <= fi_d;
      acc_q <= acc_d;
      fd_q  <= fd_d;
      sp_q  <= sp_d;
      neg_q <= neg_d;
      bad_q <= bad_d;
      fb_q  <= fb_d;
    end
  end

endmodule

FILE: src/nrmc_div.sv
// shared divider for the fixed decimal divisors and sixty, by reciprocal multiply
module nrmc_div (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  nrmc_pkg::div_req_t   req_i,
  output nrmc_pkg::div_rsp_t   rsp_o
);

  localparam logic [2:0] P_IDLE  = 3'd0;
  localparam logic [2:0] P_MUL   = 3'd1;
  localparam logic [2:0] P_SHIFT = 3'd2;
  localparam logic [2:0] P_REM   = 3'd3;
  localparam logic [2:0] P_FIX   = 3'd4;

  logic [2:0]         ph_q;
  logic               done_q;
  nrmc_pkg::div_sel_e sel_q;
  logic [31:0]        num_q, quo_q, rem_q;
  logic [63:0]        prod_q;
  logic [31:0]        recip, dvs;
  logic [5:0]         shamt;
  logic [63:0]        prod_sh;

  // recip is floor(2^shamt / divisor) with shamt = 31 + floor(log2 divisor),
  // so the quotient estimate is exact or one short
  always_comb begin
    case (sel_q)
      nrmc_pkg::DivP0:   begin recip = 32'd2147483648; shamt = 6'd31; end
      nrmc_pkg::DivP1:   begin recip = 32'd1717986918; shamt = 6'd34; end
      nrmc_pkg::DivP2:   begin recip = 32'd1374389534; shamt = 6'd37; end
      nrmc_pkg::DivP3:   begin recip = 32'd1099511627; shamt = 6'd40; end
      nrmc_pkg::DivP4:   begin recip = 32'd1759218604; shamt = 6'd44; end
      nrmc_pkg::DivP5:   begin recip = 32'd1407374883; shamt = 6'd47; end
      nrmc_pkg::DivP6:   begin recip = 32'd1125899906; shamt = 6'd50; end
      nrmc_pkg::DivP7:   begin recip = 32'd1801439850; shamt = 6'd54; end
      nrmc_pkg::DivBy60: begin recip = 32'd1145324612; shamt = 6'd36; end
      default:           begin recip = 32'd2147483648; shamt = 6'd31; end
    endcase
  end

  assign dvs     = (sel_q == nrmc_pkg::DivBy60) ? 32'd60 : nrmc_pkg::pow10(sel_q[2:0]);
  assign prod_sh = prod_q >> shamt;

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;
  assign rsp_o.rem  = rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= P_IDLE;
      done_q <= 1'b0;
      sel_q  <= nrmc_pkg::DivP0;
      num_q  <= '0;
      quo_q  <= '0;
      rem_q  <= '0;
      prod_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        num_q <= req_i.dividend;
        sel_q <= req_i.sel;
        ph_q  <= P_MUL;
      end else begin
        case (ph_q)
          P_MUL: begin
            prod_q <= num_q * recip;
            ph_q   <= P_SHIFT;
          end
          P_SHIFT: begin
            quo_q <= prod_sh[31:0];
            ph_q  <= P_REM;
          end
          P_REM: begin
            rem_q <= num_q - quo_q * dvs;
            ph_q  <= P_FIX;
          end
          P_FIX: begin
            // one correction step brings the remainder below the divisor
            if (rem_q >= dvs) begin
              quo_q <= quo_q + 32'd1;
              rem_q <= rem_q - dvs;
            end
            done_q <= 1'b1;
            ph_q   <= P_IDLE;
          end
          default: ph_q <= P_IDLE;
        endcase
      end
    end
  end

endmodule

FILE: src/nrmc_back.sv
// conversion back: turns queued fields into held results and presents them
module nrmc_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_empty_i,
  output logic           pop_o,
  input  nrmc_pkg::job_t job_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [6:0]     utc_hour_o,
  output logic [6:0]     utc_minute_o,
  output logic [6:0]     utc_second_o,
  output logic [23:0]    latitude_e5_o,
  output logic [7:0]     north_south_o,
  output logic [26:0]    longitude_e5_o,
  output logic [7:0]     east_west_o,
  output logic [6:0]     utc_day_o,
  output logic [6:0]     utc_month_o,
  output logic [11:0]    utc_year_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_T1   = 4'd1;
  localparam logic [3:0] S_T2   = 4'd2;
  localparam logic [3:0] S_T3   = 4'd3;
  localparam logic [3:0] S_L1   = 4'd4;
  localparam logic [3:0] S_L2   = 4'd5;
  localparam logic [3:0] S_L3   = 4'd6;
  localparam logic [3:0] S_D1   = 4'd7;
  localparam logic [3:0] S_D2   = 4'd8;
  localparam logic [3:0] S_FIN  = 4'd9;
  localparam logic [3:0] S_EMIT = 4'd10;

  localparam logic [23:0] LatMax = 24'd9999999;
  localparam logic [26:0] LonMax = 27'd99999999;

  logic [3:0] st_q, st_d;
  nrmc_pkg::job_t job_q, job_d;
  logic [31:0] deg_q, deg_d, prod_q, prod_d;
  logic [26:0] degm_q, degm_d;
  logic [6:0]  hour_q, hour_d, min_q, min_d, sec_q, sec_d, day_q, day_d, mon_q, mon_d;
  logic [23:0] lat_q, lat_d;
  logic [26:0] lon_q, lon_d;
  logic [7:0]  ns_q, ns_d, ew_q, ew_d;
  logic [11:0] year_q, year_d;
  logic        ov_d;
  logic [31:0] frac_scale;
  logic [40:0] prod_full;
  logic [27:0] sum;
  logic        deg_big;

  nrmc_pkg::div_req_t dreq;
  nrmc_pkg::div_rsp_t drsp;

  nrmc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dreq),
    .rsp_o  (drsp)
  );

  assign frac_scale = nrmc_pkg::pow10(3'd5 - job_q.dx);
  assign prod_full  = drsp.rem[23:0] * frac_scale[16:0];
  assign sum        = {1'b0, degm_q} + {1'b0, drsp.quo[26:0]};
  assign deg_big    = deg_q >= 32'd1000;

  always_comb begin
    st_d   = st_q;
    job_d  = job_q;
    deg_d  = deg_q;
    prod_d = prod_q;
    degm_d = degm_q;
    hour_d = hour_q;
    min_d  = min_q;
    sec_d  = sec_q;
    lat_d  = lat_q;
    lon_d  = lon_q;
    ns_d   = ns_q;
    ew_d   = ew_q;
    day_d  = day_q;
    mon_d  = mon_q;
    year_d = year_q;
    ov_d   = out_valid_o && out_stall_i;
    pop_o  = 1'b0;
    dreq.start    = 1'b0;
    dreq.dividend = drsp.quo;
    dreq.sel      = nrmc_pkg::DivP2;
    case (st_q)
      S_IDLE: begin
        if (!q_empty_i) begin
          pop_o = 1'b1;
          job_d = job_i;
          dreq.dividend = job_i.value;
          case (job_i.idx)
            nrmc_pkg::FieldTime: begin
              dreq.start = 1'b1;
              dreq.sel   = nrmc_pkg::div_sel_e'({1'b0, job_i.dx});
              st_d = S_T1;
            end
            nrmc_pkg::FieldLat, nrmc_pkg::FieldLon: begin
              dreq.start = 1'b1;
              dreq.sel   = nrmc_pkg::div_sel_e'({1'b0, job_i.dx} + 4'd2);
              st_d = S_L1;
            end
            nrmc_pkg::FieldDate: begin
              dreq.start = 1'b1;
              st_d = S_D1;
            end
            nrmc_pkg::FieldNs: begin
              ns_d = job_i.first_byte;
              st_d = S_FIN;
            end
            nrmc_pkg::FieldEw: begin
              ew_d = job_i.first_byte;
              st_d = S_FIN;
            end
            default: st_d = S_FIN;
          endcase
        end
      end
      S_T1: begin
        if (drsp.done) begin
          dreq.start = 1'b1;
          st_d = S_T2;
        end
      end
      S_T2: begin
        if (drsp.done) begin
          sec_d = drsp.rem[6:0];
          dreq.start = 1'b1;
          st_d = S_T3;
        end
      end
      S_T3: begin
        if (drsp.done) begin
          hour_d = (drsp.quo > 32'd99) ? 7'd99 : drsp.quo[6:0];
          min_d  = drsp.rem[6:0];
          st_d = S_FIN;
        end
      end
      S_L1: begin
        if (drsp.done) begin
          deg_d  = drsp.quo;
          prod_d = prod_full[31:0];
          st_d = S_L2;
        end
      end
      S_L2: begin
        degm_d = deg_q[9:0] * 17'd100000;
        dreq.start    = 1'b1;
        dreq.dividend = prod_q;
        dreq.sel      = nrmc_pkg::DivBy60;
        st_d = S_L3;
      end
      S_L3: begin
        if (drsp.done) begin
          if (job_q.idx == nrmc_pkg::FieldLat) begin
            lat_d = (deg_big || sum > {4'd0, LatMax}) ? LatMax : sum[23:0];
          end else begin
            lon_d = (deg_big || sum > {1'b0, LonMax}) ? LonMax : sum[26:0];
          end
          st_d = S_FIN;
        end
      end
      S_D1: begin
        if (drsp.done) begin
          year_d = nrmc_pkg::YearBase + drsp.rem[11:0];
          dreq.start = 1'b1;
          st_d = S_D2;
        end
      end
      S_D2: begin
        if (drsp.done) begin
          day_d = (drsp.quo > 32'd99) ? 7'd99 : drsp.quo[6:0];
          mon_d = drsp.rem[6:0];
          st_d = S_FIN;
        end
      end
      S_FIN: begin
        st_d = job_q.term ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        if (!out_valid_o || !out_stall_i) begin
          ov_d = 1'b1;
          st_d = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      out_valid_o <= 1'b0;
      hour_q      <= '0;
      min_q       <= '0;
      sec_q       <= '0;
      lat_q       <= '0;
      lon_q       <= '0;
      ns_q        <= '0;
      ew_q        <= '0;
      day_q       <= '0;
      mon_q       <= '0;
      year_q      <= nrmc_pkg::YearBase;
    end else begin
      st_q        <= st_d;
      out_valid_o <= ov_d;
      hour_q      <= hour_d;
      min_q       <= min_d;
      sec_q       <= sec_d;
      lat_q       <= lat_d;
      lon_q       <= lon_d;
      ns_q        <= ns_d;
      ew_q        <= ew_d;
      day_q       <= day_d;
      mon_q       <= mon_d;
      year_q      <= year_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q  <= job_d;
    deg_q  <= deg_d;
    prod_q <= prod_d;
    degm_q <= degm_d;
    if (st_q == S_EMIT && (!out_valid_o || !out_stall_i)) begin
      utc_hour_o     <= hour_q;
      utc_minute_o   <= min_q;
      utc_second_o   <= sec_q;
      latitude_e5_o  <= lat_q;
      north_south_o  <= ns_q;
      longitude_e5_o <= lon_q;
      east_west_o    <= ew_q;
      utc_day_o      <= day_q;
      utc_month_o    <= mon_q;
      utc_year_o     <= year_q;
    end
  end

endmodule

FILE: src/nmea_rmc_position_time_decoder_core.sv
// top level of the rmc position and time decoder
// Usage:
//   bytes of the serial stream enter on in_valid_i/rx_byte_i; in_stall_o
//   rises only while the four-entry field queue is full. one byte per cycle
//   is taken otherwise, header and payload bytes alike.
//   each comma that closes the time, position, hemisphere or date field
//   queues one transaction for the back end, which converts it with a shared
//   reciprocal-multiply divider: time takes three passes, hemispheres none.
//   a terminator ('*', a control byte or a byte above 'z') queues a closing
//   transaction; the held values appear on the result port with out_valid_o
//   high once its conversion ends and the back end has passed through its
//   finish and emit states.
//   the result register holds its value while out_valid_o and out_stall_i
//   are both high, and the back end waits with the next sentence result until
//   it is taken; the front keeps taking bytes until the queue fills.
//   talker_id_i is written through cfg_valid_i (cfg_ready_o is always high);
//   the user is to write it only while the block is idle, which the block
//   itself does not enforce.
//   reset: hunting for '$', talker 'GN', all held values zero, year 2000,
//   no result pending.
module nmea_rmc_position_time_decoder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] talker_id_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [6:0]  utc_hour_o,
  output logic [6:0]  utc_minute_o,
  output logic [6:0]  utc_second_o,
  output logic [23:0] latitude_e5_o,
  output logic [7:0]  north_south_o,
  output logic [26:0] longitude_e5_o,
  output logic [7:0]  east_west_o,
  output logic [6:0]  utc_day_o,
  output logic [6:0]  utc_month_o,
  output logic [11:0] utc_year_o
);

  nrmc_pkg::job_t push_job, pop_job;
  logic push, pop, q_full, q_empty;

  nrmc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .talker_id_i (talker_id_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .rx_byte_i   (rx_byte_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .job_o       (push_job)
  );

  nrmc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .full_o      (q_full),
    .pop_i       (pop),
    .pop_data_o  (pop_job),
    .empty_o     (q_empty)
  );

  nrmc_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_empty_i      (q_empty),
    .pop_o          (pop),
    .job_i          (pop_job),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .utc_hour_o     (utc_hour_o),
    .utc_minute_o   (utc_minute_o),
    .utc_second_o   (utc_second_o),
    .latitude_e5_o  (latitude_e5_o),
    .north_south_o  (north_south_o),
    .longitude_e5_o (longitude_e5_o),
    .east_west_o    (east_west_o),
    .utc_day_o      (utc_day_o),
    .utc_month_o    (utc_month_o),
    .utc_year_o     (utc_year_o)
  );

endmodule

FILE: src/nrmc_checker.sv
// port-level checks for the rmc decoder and their bind
module nrmc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [6:0]  utc_minute_o,
  input logic [6:0]  utc_second_o,
  input logic [11:0] utc_year_o,
  input logic [23:0] latitude_e5_o
);

  // a stalled result stays offered
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o) else $error("result dropped under stall");

  a_year_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (utc_year_o >= 12'd2000 && utc_year_o <= 12'd2099))
    else $error("year out of range");

  a_min_sec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (utc_minute_o <= 7'd99 && utc_second_o <= 7'd99))
    else $error("minute or second out of range");

  a_lat_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> latitude_e5_o <= 24'd9999999) else $error("latitude not saturated");

endmodule

bind nmea_rmc_position_time_decoder_core nrmc_checker u_nrmc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .utc_minute_o  (utc_minute_o),
  .utc_second_o  (utc_second_o),
  .utc_year_o    (utc_year_o),
  .latitude_e5_o (latitude_e5_o)
);
